@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/aie_pkg.sv @@
package aie_pkg;

  localparam int CMD_W  = 7;
  localparam int WORD_W = 16;
  localparam int PC_W   = 15;

  localparam int MEM_DEPTH_DEF = 32768;

  localparam logic [CMD_W-1:0] OP_OUT_CHAR = 7'd1;
  localparam logic [CMD_W-1:0] OP_IN_CHAR  = 7'd2;
  localparam logic [CMD_W-1:0] OP_OUT_NUM  = 7'd3;
  localparam logic [CMD_W-1:0] OP_IN_NUM   = 7'd4;
  localparam logic [CMD_W-1:0] OP_ADD      = 7'd5;
  localparam logic [CMD_W-1:0] OP_SUB      = 7'd6;
  localparam logic [CMD_W-1:0] OP_JUMP     = 7'd7;
  localparam logic [CMD_W-1:0] OP_MOVE     = 7'd12;
  localparam logic [CMD_W-1:0] OP_LOAD     = 7'd13;
  localparam logic [CMD_W-1:0] OP_SAVE     = 7'd14;
  localparam logic [CMD_W-1:0] OP_SET      = 7'd15;
  localparam logic [CMD_W-1:0] OP_END      = 7'd99;

  // Write request into the data store; the store uses the low address bits.
  typedef struct packed {
    logic              en;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } aie_wr_t;

  // Partial remainder of x by depth: conditional subtract of depth << k for k in [lo, hi].
  // Running hi..lo over 15..0 in two calls gives the full remainder.
  function automatic logic [WORD_W-1:0] mod_reduce(input logic [WORD_W-1:0] x,
                                                   input int depth,
                                                   input int hi,
                                                   input int lo);
    logic [31:0]       step;
    logic [WORD_W-1:0] r;
    r = x;
    for (int k = 15; k >= 0; k--) begin
      step = 32'(depth) << k;
      if (k <= hi && k >= lo && step <= 32'h0000_FFFF && {16'b0, r} >= step) begin
        r = r - step[WORD_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/aie_if.sv @@
interface aie_instr_if
  import aie_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] arg_first;
  logic signed [WORD_W-1:0] arg_second;
  logic signed [WORD_W-1:0] in_value;

  modport source (output valid, cmd, arg_first, arg_second, in_value, input ready);
  modport sink   (input valid, cmd, arg_first, arg_second, in_value, output ready);
endinterface

interface aie_result_if
  import aie_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     out_valid;
  logic                     out_is_number;
  logic signed [WORD_W-1:0] out_value;
  logic [PC_W-1:0]          next_pc;
  logic                     halted;

  modport source (output valid, out_valid, out_is_number, out_value, next_pc, halted,
                  input ready);
  modport sink   (input valid, out_valid, out_is_number, out_value, next_pc, halted,
                  output ready);
endinterface

@@ rtl/aie_store.sv @@
`include "assert_macros.svh"

module aie_store
  import aie_pkg::*;
#(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [$clog2(MEM_DEPTH)-1:0] rd_addr,
  input  aie_wr_t                     wr,
  output logic [WORD_W-1:0]           rd_data,
  output logic                        busy
);

  localparam int AW = $clog2(MEM_DEPTH);

  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [WORD_W-1:0] mem_q;
  logic [AW-1:0]     clr_addr;
  logic              clearing;
  logic              byp_hit;
  logic [WORD_W-1:0] byp_data;
  logic [AW-1:0]     wr_addr;

  assign wr_addr = wr.addr[AW-1:0];
  assign busy    = clearing;

  // Zero the whole array once after reset, one entry a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // A read that meets a write to the same entry on the same edge takes the new data.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (rd_en) begin
      byp_hit <= wr.en && !clearing && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr.data;
    end
  end

  assign rd_data = byp_hit ? byp_data : mem_q;

  `ASSERT_NEVER(a_no_read_in_clear, clk, rst, clearing && rd_en, "read during clearing pass")
  `ASSERT_ALWAYS(a_bypass, clk, rst, rd_en && wr.en && !clearing && wr_addr == rd_addr |=> rd_data == $past(wr.data), "read missed a coincident write")
  `ASSERT_ALWAYS(a_clear_len, clk, rst, $fell(clearing) |-> $past(clr_addr) == AW'(MEM_DEPTH - 1), "clearing pass ended early")

endmodule

@@ rtl/accumulator_instruction_execute.sv @@
// Executes one instruction per transaction on a 16-bit accumulator machine whose data
// memory is a synchronous array of MEM_DEPTH words with one read and one write port.
// Throughput is one instruction per cycle while result.ready is high; an instruction
// passes the address stage (address reduction and memory read), then the execute
// stage into the output register. Load and move read the memory, save and move write
// it, and a read that lands on the entry the previous instruction writes in the same
// cycle is served from a bypass register. After reset the memory is zeroed one word
// per cycle, MEM_DEPTH words (32768 by default), and instr.ready is low until it is
// done. Once END executes the machine holds its state and answers every later
// instruction with halted set until reset.
`include "assert_macros.svh"

module accumulator_instruction_execute
  import aie_pkg::*;
#(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  aie_instr_if.sink    instr,
  aie_result_if.source result
);

  localparam int AW = $clog2(MEM_DEPTH);

  // address stage
  logic              a_valid;
  logic [CMD_W-1:0]  a_cmd;
  logic [WORD_W-1:0] a_arg_first;
  logic [WORD_W-1:0] a_in_value;
  logic [WORD_W-1:0] a_src_part;
  logic [WORD_W-1:0] a_dst_part;

  // execute stage
  logic              b_valid;
  logic [CMD_W-1:0]  b_cmd;
  logic [WORD_W-1:0] b_arg_first;
  logic [WORD_W-1:0] b_in_value;
  logic [AW-1:0]     b_src;
  logic [AW-1:0]     b_dst;

  // output register
  logic              o_valid;
  logic              o_out_valid;
  logic              o_is_number;
  logic [WORD_W-1:0] o_value;
  logic [PC_W-1:0]   o_pc;
  logic              o_halted;

  // architectural registers
  logic [WORD_W-1:0] acc;
  logic [PC_W-1:0]   pc;
  logic              halt;

  logic              in_take;
  logic              o_free;
  logic              b_adv;
  logic              b_free;
  logic              a_adv;
  logic              a_free;
  logic              busy;
  logic [WORD_W-1:0] rd_rem;
  logic [WORD_W-1:0] dst_rem;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     dst_addr;
  logic [WORD_W-1:0] rd_data;
  aie_wr_t           wr;

  logic [WORD_W-1:0] acc_next;
  logic [PC_W-1:0]   pc_next;
  logic              halt_next;
  logic              x_out_valid;
  logic              x_is_number;
  logic [WORD_W-1:0] x_value;
  logic              x_wen;
  logic [AW-1:0]     x_waddr;
  logic [WORD_W-1:0] x_wdata;

  assign o_free      = !o_valid || result.ready;
  assign b_adv       = b_valid && o_free;
  assign b_free      = !b_valid || b_adv;
  assign a_adv       = a_valid && b_free;
  assign a_free      = !a_valid || a_adv;
  assign instr.ready = !busy && a_free;
  assign in_take     = instr.valid && instr.ready;

  assign rd_rem   = mod_reduce(a_src_part, MEM_DEPTH, 5, 0);
  assign dst_rem  = mod_reduce(a_dst_part, MEM_DEPTH, 5, 0);
  assign rd_addr  = rd_rem[AW-1:0];
  assign dst_addr = dst_rem[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_cmd       <= instr.cmd;
      a_arg_first <= $unsigned(instr.arg_first);
      a_in_value  <= $unsigned(instr.in_value);
      a_src_part  <= mod_reduce($unsigned(instr.arg_first), MEM_DEPTH, 15, 6);
      a_dst_part  <= mod_reduce($unsigned(instr.arg_second), MEM_DEPTH, 15, 6);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_adv) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_cmd       <= a_cmd;
      b_arg_first <= a_arg_first;
      b_in_value  <= a_in_value;
      b_src       <= rd_addr;
      b_dst       <= dst_addr;
    end
  end

  always_comb begin
    acc_next    = acc;
    pc_next     = pc;
    halt_next   = halt;
    x_out_valid = 1'b0;
    x_is_number = 1'b0;
    x_value     = '0;
    x_wen       = 1'b0;
    x_waddr     = b_src;
    x_wdata     = rd_data;
    if (!halt) begin
      pc_next = pc + 1'b1;
      unique case (b_cmd) inside
        OP_OUT_CHAR: begin
          x_out_valid = 1'b1;
          x_value     = acc;
        end
        OP_OUT_NUM: begin
          x_out_valid = 1'b1;
          x_is_number = 1'b1;
          x_value     = acc;
        end
        OP_IN_CHAR, OP_IN_NUM: acc_next = b_in_value;
        OP_ADD:  acc_next = acc + b_arg_first;
        OP_SUB:  acc_next = acc - b_arg_first;
        OP_JUMP: pc_next = b_arg_first[PC_W-1:0];
        OP_MOVE: begin
          x_wen   = 1'b1;
          x_waddr = b_dst;
        end
        OP_LOAD: acc_next = rd_data;
        OP_SAVE: begin
          x_wen   = 1'b1;
          x_wdata = acc;
        end
        OP_SET:  acc_next = b_arg_first;
        OP_END: begin
          halt_next = 1'b1;
          pc_next   = pc;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    wr.en   = b_adv && x_wen;
    wr.addr = WORD_W'(x_waddr);
    wr.data = x_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      pc   <= '0;
      halt <= 1'b0;
    end else if (b_adv) begin
      acc  <= acc_next;
      pc   <= pc_next;
      halt <= halt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (b_adv) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      o_out_valid <= x_out_valid;
      o_is_number <= x_is_number;
      o_value     <= x_value;
      o_pc        <= pc_next;
      o_halted    <= halt_next;
    end
  end

  assign result.valid         = o_valid;
  assign result.out_valid     = o_out_valid;
  assign result.out_is_number = o_is_number;
  assign result.out_value     = $signed(o_value);
  assign result.next_pc       = o_pc;
  assign result.halted        = o_halted;

  aie_store #(
    .MEM_DEPTH(MEM_DEPTH)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (a_adv),
    .rd_addr(rd_addr),
    .wr     (wr),
    .rd_data(rd_data),
    .busy   (busy)
  );

  `ASSERT_NEVER(a_no_take_busy, clk, rst, busy && instr.ready,
                "instruction taken during clearing pass")
  `ASSERT_ALWAYS(a_halt_sticks, clk, rst, halt |=> halt, "halt cleared without reset")
  `ASSERT_ALWAYS(a_jump_pc, clk, rst,
                 b_adv && !halt && b_cmd == OP_JUMP |=> pc == $past(b_arg_first[PC_W-1:0]),
                 "jump target not taken")

endmodule
